// ----- rtl/rtp_h264_stream_depacketizer_unit_defines.svh -----
// Assertion macros shared by the depacketizer checker.
`ifndef RTP_H264_STREAM_DEPACKETIZER_UNIT_DEFINES_SVH
`define RTP_H264_STREAM_DEPACKETIZER_UNIT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define RTPH_ASSERT_NOW(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define RTPH_ASSERT_NEXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/rtph264_pkg.sv -----
// Types and constants of the RTP H.264 stream depacketizer.
package rtph264_pkg;

  typedef enum logic [3:0] {
    PH_HUNT,
    PH_CHAN,
    PH_LENHI,
    PH_LENLO,
    PH_SKIP,
    PH_RTP0,
    PH_RTPHDR,
    PH_PAYFIRST,
    PH_FUHDR,
    PH_BODY
  } phase_t;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_SINGLE,
    KIND_STAP,
    KIND_FU
  } kind_t;

  typedef enum logic [1:0] {
    SUB_LENHI,
    SUB_LENLO,
    SUB_NAL
  } sub_t;

  // results caused by one stream byte: marker, start code, data byte (in that order)
  typedef struct packed {
    logic       mk;
    logic       mk_disc;
    logic       sc;
    logic       sc_empty;
    logic       db;
    logic       db_last;
    logic [7:0] db_byte;
  } grp_t;

  localparam logic [7:0]  FRAME_MARK   = 8'h24;
  localparam logic [15:0] RTP_HDR_MIN  = 16'd12;
  localparam logic [6:0]  RTP_HDR_BASE = 7'd12;
  localparam logic [4:0]  NAL_TYPE_LO  = 5'd1;
  localparam logic [4:0]  NAL_TYPE_HI  = 5'd23;
  localparam logic [4:0]  NAL_STAP_A   = 5'd24;
  localparam logic [4:0]  NAL_FU_A     = 5'd28;
  localparam logic [7:0]  SC_LAST_BYTE = 8'h01;

endpackage

// ----- rtl/rtph264_parser.sv -----
// Frame and RTP payload parser: one stream byte in, one result group out.
module rtph264_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire,
  input  logic [7:0]         in_byte,
  input  logic [7:0]         video_channel,
  output rtph264_pkg::grp_t  grp
);

  rtph264_pkg::phase_t phase_r, phase_nxt, eph;
  rtph264_pkg::kind_t  kind_r, kind_nxt;
  rtph264_pkg::sub_t   sub_r, sub_nxt;
  logic [7:0]  chan_r, chan_nxt;
  logic [15:0] fbl_r, fbl_nxt;
  logic [6:0]  rhl_r, rhl_nxt;
  logic        fo_r, fo_nxt;
  logic        fe_r, fe_nxt;
  logic [7:0]  alh_r, alh_nxt;
  logic [15:0] anl_r, anl_nxt;

  logic        pkt_phase;
  logic [15:0] left;
  logic        left_zero;
  logic [15:0] len_word;
  logic [6:0]  hlen;
  logic [6:0]  rhl_dec;
  logic [4:0]  nal_type;
  logic        is_single;
  logic        is_stap;
  logic        fu_ok;
  logic [15:0] nlen;
  logic [15:0] anl_dec;
  logic        fu_end;

  always_comb begin
    pkt_phase = !(phase_r == rtph264_pkg::PH_HUNT || phase_r == rtph264_pkg::PH_CHAN ||
                  phase_r == rtph264_pkg::PH_LENHI || phase_r == rtph264_pkg::PH_LENLO);
    eph       = (pkt_phase && fbl_r == 16'd0) ? rtph264_pkg::PH_HUNT : phase_r;
    left      = fbl_r - 16'd1;
    left_zero = (fbl_r == 16'd1);
    len_word  = {fbl_r[15:8], in_byte};
    hlen      = rtph264_pkg::RTP_HDR_BASE + {1'b0, in_byte[3:0], 2'b00};
    rhl_dec   = (rhl_r != 7'd0) ? rhl_r - 7'd1 : 7'd0;
    nal_type  = in_byte[4:0];
    is_single = (nal_type >= rtph264_pkg::NAL_TYPE_LO) && (nal_type <= rtph264_pkg::NAL_TYPE_HI);
    is_stap   = (nal_type == rtph264_pkg::NAL_STAP_A);
    fu_ok     = (nal_type == rtph264_pkg::NAL_FU_A) && !left_zero;
    nlen      = {alh_r, in_byte};
    anl_dec   = (anl_r != 16'd0) ? anl_r - 16'd1 : 16'd0;
    fu_end    = left_zero && in_byte[6];
  end

  // next parse phase
  always_comb begin
    phase_nxt = phase_r;
    case (eph)
      rtph264_pkg::PH_HUNT: begin
        phase_nxt = (in_byte == rtph264_pkg::FRAME_MARK) ? rtph264_pkg::PH_CHAN
                                                        : rtph264_pkg::PH_HUNT;
      end
      rtph264_pkg::PH_CHAN:  phase_nxt = rtph264_pkg::PH_LENHI;
      rtph264_pkg::PH_LENHI: phase_nxt = rtph264_pkg::PH_LENLO;
      rtph264_pkg::PH_LENLO: begin
        if (len_word == 16'd0) begin
          phase_nxt = rtph264_pkg::PH_HUNT;
        end else if (chan_r != video_channel || len_word < rtph264_pkg::RTP_HDR_MIN) begin
          phase_nxt = rtph264_pkg::PH_SKIP;
        end else begin
          phase_nxt = rtph264_pkg::PH_RTP0;
        end
      end
      rtph264_pkg::PH_RTP0: begin
        phase_nxt = (fbl_r <= {9'd0, hlen}) ? rtph264_pkg::PH_SKIP : rtph264_pkg::PH_RTPHDR;
      end
      rtph264_pkg::PH_RTPHDR: begin
        if (rhl_dec == 7'd0) begin
          phase_nxt = rtph264_pkg::PH_PAYFIRST;
        end
      end
      rtph264_pkg::PH_PAYFIRST: begin
        if (is_single || is_stap) begin
          phase_nxt = rtph264_pkg::PH_BODY;
        end else if (fu_ok) begin
          phase_nxt = rtph264_pkg::PH_FUHDR;
        end else begin
          phase_nxt = rtph264_pkg::PH_SKIP;
        end
      end
      rtph264_pkg::PH_FUHDR: begin
        phase_nxt = (!in_byte[7] && !fo_r) ? rtph264_pkg::PH_SKIP : rtph264_pkg::PH_BODY;
      end
      rtph264_pkg::PH_BODY: begin
        case (kind_r)
          rtph264_pkg::KIND_SINGLE, rtph264_pkg::KIND_FU: phase_nxt = rtph264_pkg::PH_BODY;
          rtph264_pkg::KIND_STAP: begin
            case (sub_r)
              rtph264_pkg::SUB_LENHI: begin
                if (fbl_r < 16'd3) begin
                  phase_nxt = rtph264_pkg::PH_SKIP;
                end
              end
              rtph264_pkg::SUB_LENLO: begin
                if (nlen > left) begin
                  phase_nxt = rtph264_pkg::PH_SKIP;
                end
              end
              rtph264_pkg::SUB_NAL: phase_nxt = rtph264_pkg::PH_BODY;
              default: phase_nxt = rtph264_pkg::PH_SKIP;
            endcase
          end
          default: phase_nxt = rtph264_pkg::PH_SKIP;
        endcase
      end
      default: phase_nxt = rtph264_pkg::PH_SKIP;
    endcase
    if (eph != rtph264_pkg::PH_HUNT && pkt_phase && left_zero) begin
      phase_nxt = rtph264_pkg::PH_HUNT;
    end
  end

  // context registers and result group
  always_comb begin
    kind_nxt = kind_r;
    sub_nxt  = sub_r;
    chan_nxt = chan_r;
    fbl_nxt  = fbl_r;
    rhl_nxt  = rhl_r;
    fo_nxt   = fo_r;
    fe_nxt   = fe_r;
    alh_nxt  = alh_r;
    anl_nxt  = anl_r;
    grp      = '0;
    case (eph)
      rtph264_pkg::PH_HUNT:  fbl_nxt = fbl_r;
      rtph264_pkg::PH_CHAN:  chan_nxt = in_byte;
      rtph264_pkg::PH_LENHI: fbl_nxt = {in_byte, 8'h00};
      rtph264_pkg::PH_LENLO: fbl_nxt = len_word;
      default:               fbl_nxt = left;
    endcase
    case (eph)
      rtph264_pkg::PH_RTP0: begin
        rhl_nxt = hlen - 7'd1;
      end
      rtph264_pkg::PH_RTPHDR: begin
        rhl_nxt = rhl_dec;
      end
      rtph264_pkg::PH_PAYFIRST: begin
        if (is_single || is_stap) begin
          if (fo_r) begin
            grp.mk      = 1'b1;
            grp.mk_disc = 1'b1;
            fo_nxt      = 1'b0;
            fe_nxt      = 1'b0;
          end
          if (is_single) begin
            grp.sc      = 1'b1;
            grp.db      = 1'b1;
            grp.db_byte = in_byte;
            grp.db_last = left_zero;
            kind_nxt    = rtph264_pkg::KIND_SINGLE;
          end else begin
            kind_nxt = rtph264_pkg::KIND_STAP;
            sub_nxt  = rtph264_pkg::SUB_LENHI;
          end
        end else if (fu_ok) begin
          alh_nxt  = in_byte;
          kind_nxt = rtph264_pkg::KIND_FU;
        end else begin
          kind_nxt = rtph264_pkg::KIND_NONE;
        end
      end
      rtph264_pkg::PH_FUHDR: begin
        if (in_byte[7]) begin
          if (fo_r) begin
            grp.mk      = 1'b1;
            grp.mk_disc = 1'b1;
          end
          grp.sc      = 1'b1;
          grp.db      = 1'b1;
          grp.db_byte = {alh_r[7:5], in_byte[4:0]};
          grp.db_last = fu_end;
          fo_nxt      = !fu_end;
          fe_nxt      = in_byte[6] && !fu_end;
        end else if (fo_r) begin
          if (fu_end) begin
            grp.mk = 1'b1;
          end
          fo_nxt = !fu_end;
          fe_nxt = in_byte[6] && !fu_end;
        end
      end
      rtph264_pkg::PH_BODY: begin
        case (kind_r)
          rtph264_pkg::KIND_SINGLE: begin
            grp.db      = 1'b1;
            grp.db_byte = in_byte;
            grp.db_last = left_zero;
          end
          rtph264_pkg::KIND_FU: begin
            if (fo_r) begin
              grp.db      = 1'b1;
              grp.db_byte = in_byte;
              grp.db_last = left_zero && fe_r;
              if (left_zero && fe_r) begin
                fo_nxt = 1'b0;
                fe_nxt = 1'b0;
              end
            end
          end
          rtph264_pkg::KIND_STAP: begin
            case (sub_r)
              rtph264_pkg::SUB_LENHI: begin
                if (fbl_r >= 16'd3) begin
                  alh_nxt = in_byte;
                  sub_nxt = rtph264_pkg::SUB_LENLO;
                end
              end
              rtph264_pkg::SUB_LENLO: begin
                if (nlen <= left) begin
                  grp.sc       = 1'b1;
                  grp.sc_empty = (nlen == 16'd0);
                  anl_nxt      = nlen;
                  sub_nxt      = (nlen == 16'd0) ? rtph264_pkg::SUB_LENHI
                                                 : rtph264_pkg::SUB_NAL;
                end
              end
              rtph264_pkg::SUB_NAL: begin
                grp.db      = 1'b1;
                grp.db_byte = in_byte;
                grp.db_last = (anl_dec == 16'd0);
                anl_nxt     = anl_dec;
                if (anl_dec == 16'd0) begin
                  sub_nxt = rtph264_pkg::SUB_LENHI;
                end
              end
              default: sub_nxt = sub_r;
            endcase
          end
          default: kind_nxt = kind_r;
        endcase
      end
      default: rhl_nxt = rhl_r;
    endcase
    if (eph != rtph264_pkg::PH_HUNT && pkt_phase && left_zero) begin
      kind_nxt = rtph264_pkg::KIND_NONE;
      sub_nxt  = rtph264_pkg::SUB_LENHI;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= rtph264_pkg::PH_HUNT;
      kind_r  <= rtph264_pkg::KIND_NONE;
      sub_r   <= rtph264_pkg::SUB_LENHI;
      chan_r  <= 8'd0;
      fbl_r   <= 16'd0;
      rhl_r   <= 7'd0;
      fo_r    <= 1'b0;
      fe_r    <= 1'b0;
      alh_r   <= 8'd0;
      anl_r   <= 16'd0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      kind_r  <= kind_nxt;
      sub_r   <= sub_nxt;
      chan_r  <= chan_nxt;
      fbl_r   <= fbl_nxt;
      rhl_r   <= rhl_nxt;
      fo_r    <= fo_nxt;
      fe_r    <= fe_nxt;
      alh_r   <= alh_nxt;
      anl_r   <= anl_nxt;
    end
  end

endmodule

// ----- rtl/rtph264_emit.sv -----
// Result group unpacker and output register: one result item per cycle while out_stall is low.
module rtph264_emit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              grp_avail,
  input  rtph264_pkg::grp_t grp_head,
  output logic              grp_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_byte,
  output logic              out_byte_valid,
  output logic              out_nal_first,
  output logic              out_nal_last,
  output logic              out_discard
);

  localparam logic [2:0] SC_LEN = 3'd4;

  typedef struct packed {
    logic       mk;
    logic       mk_disc;
    logic [2:0] sc_cnt;
    logic       sc_empty;
    logic       db;
    logic       db_last;
    logic [7:0] db_byte;
  } pend_t;

  pend_t      cur_r, cur_nxt, src, rem;
  logic       have;
  logic       adv;
  logic       emit;
  logic [7:0] it_byte;
  logic       it_bv;
  logic       it_first;
  logic       it_last;
  logic       it_disc;

  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_bv_r;
  logic       out_first_r;
  logic       out_last_r;
  logic       out_disc_r;

  always_comb begin
    have = cur_r.mk || (cur_r.sc_cnt != 3'd0) || cur_r.db;
    adv  = !out_valid_r || !out_stall;
    emit = adv && (have || grp_avail);
    grp_pop = adv && !have && grp_avail;
    if (have) begin
      src = cur_r;
    end else begin
      src.mk       = grp_head.mk;
      src.mk_disc  = grp_head.mk_disc;
      src.sc_cnt   = grp_head.sc ? SC_LEN : 3'd0;
      src.sc_empty = grp_head.sc_empty;
      src.db       = grp_head.db;
      src.db_last  = grp_head.db_last;
      src.db_byte  = grp_head.db_byte;
    end
    rem      = src;
    it_byte  = 8'h00;
    it_bv    = 1'b1;
    it_first = 1'b0;
    it_last  = 1'b0;
    it_disc  = 1'b0;
    if (src.mk) begin
      it_bv   = 1'b0;
      it_last = 1'b1;
      it_disc = src.mk_disc;
      rem.mk  = 1'b0;
    end else if (src.sc_cnt != 3'd0) begin
      it_byte    = (src.sc_cnt == 3'd1) ? rtph264_pkg::SC_LAST_BYTE : 8'h00;
      it_first   = (src.sc_cnt == SC_LEN);
      it_last    = (src.sc_cnt == 3'd1) && src.sc_empty;
      rem.sc_cnt = src.sc_cnt - 3'd1;
    end else begin
      it_byte = src.db_byte;
      it_last = src.db_last;
      rem.db  = 1'b0;
    end
    cur_nxt = emit ? rem : cur_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cur_r <= cur_nxt;
      if (adv) begin
        out_valid_r <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte_r  <= it_byte;
      out_bv_r    <= it_bv;
      out_first_r <= it_first;
      out_last_r  <= it_last;
      out_disc_r  <= it_disc;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_byte       = out_byte_r;
  assign out_byte_valid = out_bv_r;
  assign out_nal_first  = out_first_r;
  assign out_nal_last   = out_last_r;
  assign out_discard    = out_disc_r;

endmodule

// ----- rtl/rtp_h264_stream_depacketizer_unit.sv -----
// Top level of the RTP-over-TCP H.264 depacketizer.
//
// Input channel: one byte of the interleaved stream per item (in_valid,
// in_stall, in_byte). Output channel: one Annex B result per item with
// out_byte, out_byte_valid, out_nal_first, out_nal_last and out_discard.
// Config: cfg_valid/cfg_ready write cfg_video_channel; cfg_ready is always
// high. Write it only while the block is idle.
// A stream byte goes through the input register, the group queue and
// the output register before its first result shows. Each byte is
// parsed after the input register and yields a group of 0 to 6
// results, held in a group queue of GRP_DEPTH entries. The output side
// drains one result per cycle while out_stall is low; input takes one
// byte per cycle while the queue has room and stalls when it is full.
// Reset clears the parser to hunting for a frame mark, empties the
// queue and drops out_valid. When out_stall is high the current result
// holds and the queue, then the input side, back up.
module rtp_h264_stream_depacketizer_unit #(
  parameter int GRP_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_byte_valid,
  output logic       out_nal_first,
  output logic       out_nal_last,
  output logic       out_discard,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_video_channel
);

  localparam int AW = (GRP_DEPTH > 1) ? $clog2(GRP_DEPTH) : 1;
  localparam int CW = $clog2(GRP_DEPTH + 1);

  logic [7:0]        vid_chan_r;
  logic              in_valid_r;
  logic [7:0]        in_byte_r;
  logic              fire;
  rtph264_pkg::grp_t grp;
  logic              push;
  logic              pop;
  logic              grp_full;

  rtph264_pkg::grp_t grp_mem [GRP_DEPTH];
  logic [AW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]     cnt_r, cnt_nxt;

  assign cfg_ready = 1'b1;
  assign grp_full  = (cnt_r == CW'(GRP_DEPTH));
  assign in_stall  = in_valid_r && grp_full;
  assign fire      = in_valid_r && !grp_full;
  assign push      = fire && (grp.mk || grp.sc || grp.db);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vid_chan_r <= 8'd0;
    end else if (cfg_valid && cfg_ready) begin
      vid_chan_r <= cfg_video_channel;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      in_byte_r <= in_byte;
    end
  end

  rtph264_parser u_parser (
    .clk           (clk),
    .rst_n         (rst_n),
    .fire          (fire),
    .in_byte       (in_byte_r),
    .video_channel (vid_chan_r),
    .grp           (grp)
  );

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (!push && pop) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(GRP_DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(GRP_DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      grp_mem[wr_ptr_r] <= grp;
    end
  end

  rtph264_emit u_emit (
    .clk            (clk),
    .rst_n          (rst_n),
    .grp_avail      (cnt_r != '0),
    .grp_head       (grp_mem[rd_ptr_r]),
    .grp_pop        (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_byte_valid (out_byte_valid),
    .out_nal_first  (out_nal_first),
    .out_nal_last   (out_nal_last),
    .out_discard    (out_discard)
  );

endmodule

// ----- rtl/rtph264_checker.sv -----
// Port-level checker for the depacketizer and its bind.
`include "rtp_h264_stream_depacketizer_unit_defines.svh"

module rtph264_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       out_byte_valid,
  input logic       out_nal_first,
  input logic       out_nal_last,
  input logic       out_discard
);

  `RTPH_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_byte) && $stable(out_nal_last) && $stable(out_byte_valid), "stalled result changed")

  `RTPH_ASSERT_NOW(a_first_is_zero, out_valid && out_nal_first, out_byte_valid && out_byte == 8'h00 && !out_nal_last && !out_discard, "bad first start code byte")

  `RTPH_ASSERT_NOW(a_marker_shape, out_valid && !out_byte_valid, out_nal_last && out_byte == 8'h00, "close marker without nal_last")

  `RTPH_ASSERT_NOW(a_discard_marker, out_valid && out_discard, !out_byte_valid && out_nal_last, "discard on a data byte")

  `RTPH_ASSERT_NEXT(a_sc_follows, out_valid && out_nal_first && !out_stall, out_valid && out_byte_valid && out_byte == 8'h00 && !out_nal_first && !out_nal_last, "start code broken")

endmodule

bind rtp_h264_stream_depacketizer_unit rtph264_checker u_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_byte       (out_byte),
  .out_byte_valid (out_byte_valid),
  .out_nal_first  (out_nal_first),
  .out_nal_last   (out_nal_last),
  .out_discard    (out_discard)
);
